@@ hw/rtl/ssnf_pkg.sv @@
// Shared types, constants and small lookup functions for the
// seven-segment number formatter. No dependencies.
package ssnf_pkg;

  // field widths
  localparam int unsigned VALUE_W = 24;
  localparam int unsigned DP_W    = 3;
  localparam int unsigned SEG_W   = 8;
  localparam int unsigned SEL_W   = 4;
  localparam int unsigned POS_W   = 2;
  localparam int unsigned R_W     = 14;  // rounded value, at most 9999 when in range

  // segment patterns, active high, bit 7 is the point
  localparam logic [SEG_W-1:0] SEG_BLANK = 8'b0000_0000;
  localparam logic [SEG_W-1:0] SEG_MINUS = 8'b0100_0000;
  localparam logic [SEG_W-1:0] SEG_E     = 8'b0111_1001;
  localparam logic [SEG_W-1:0] SEG_R     = 8'b0101_0000;
  localparam logic [SEG_W-1:0] SEG_POINT = 8'b1000_0000;

  // digit enable of the leftmost digit, others follow by right shift
  localparam logic [SEL_W-1:0] SEL_FIRST = 4'b1000;

  // decimal places code that shows the value unscaled
  localparam logic [1:0] DP_THREE = 2'd3;

  // frame index within the three-frame error display
  localparam logic [1:0] BEAT_E    = 2'd0;
  localparam logic [1:0] BEAT_LAST = 2'd2;

  // reciprocal scaling for the rounding divide, exact for in-range sums
  localparam int unsigned RECIP_W     = 30;
  localparam int unsigned RECIP_SHIFT = 33;
  localparam int unsigned PROD_W      = VALUE_W + RECIP_W;

  // reciprocals for digit extraction, exact for values up to 9999
  localparam int unsigned DIV1000_M = 16778;
  localparam int unsigned DIV1000_S = 24;
  localparam int unsigned DIV100_M  = 10486;
  localparam int unsigned DIV100_S  = 20;
  localparam int unsigned DIV10_M   = 13108;
  localparam int unsigned DIV10_S   = 17;

  // one classified word waiting for the back end
  typedef struct packed {
    logic             err;
    logic [SEG_W-1:0] seg;
    logic [POS_W-1:0] pos;
  } ssnf_entry_t;

  // glyph of one decimal digit
  function automatic logic [SEG_W-1:0] glyph(input logic [3:0] d);
    logic [SEG_W-1:0] g;
    unique case (d)
      4'd0:    g = 8'h3F;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'h5B;
      4'd3:    g = 8'h4F;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'h6D;
      4'd6:    g = 8'h7D;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h7F;
      4'd9:    g = 8'h6F;
      default: g = SEG_BLANK;
    endcase
    return g;
  endfunction

  // half-up rounding offset per decimal places
  function automatic logic [VALUE_W-1:0] round_add(input logic [1:0] dp);
    logic [VALUE_W-1:0] a;
    unique case (dp)
      2'd0:    a = 24'd500;
      2'd1:    a = 24'd50;
      2'd2:    a = 24'd5;
      default: a = 24'd0;
    endcase
    return a;
  endfunction

  // ceil(2^33 / divisor) per decimal places; unscaled case bypasses it
  function automatic logic [RECIP_W-1:0] recip(input logic [1:0] dp);
    logic [RECIP_W-1:0] m;
    unique case (dp)
      2'd0:    m = 30'd8589935;
      2'd1:    m = 30'd85899346;
      2'd2:    m = 30'd858993460;
      default: m = 30'd0;
    endcase
    return m;
  endfunction

  // smallest rounded sum that overflows the display
  function automatic logic [VALUE_W-1:0] ovf_limit(input logic [1:0] dp, input logic neg);
    logic [VALUE_W-1:0] t;
    unique case (dp)
      2'd0:    t = neg ? 24'd1000000 : 24'd10000000;
      2'd1:    t = neg ? 24'd100000  : 24'd1000000;
      2'd2:    t = neg ? 24'd10000   : 24'd100000;
      default: t = neg ? 24'd1000    : 24'd10000;
    endcase
    return t;
  endfunction

endpackage

@@ hw/rtl/ssnf_fifo.sv @@
// Small entry queue between the formatter front end and frame back end.
// Depends on ssnf_pkg for the entry type.
module ssnf_fifo import ssnf_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  ssnf_entry_t entry_i,
  output logic        full_o,
  input  logic        pop_i,
  output ssnf_entry_t entry_o,
  output logic        empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ssnf_entry_t        mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ hw/rtl/ssnf_front.sv @@
// Front end: takes words, rounds and range-checks them, splits digits,
// builds the selected digit pattern and queues one entry per word. Uses ssnf_pkg.
module ssnf_front import ssnf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic [DP_W-1:0]           dp_i,
  output logic                      push_o,
  output ssnf_entry_t               entry_o,
  input  logic                      full_i
);

  // stage 1: rounded magnitude
  logic               v1_q, neg1_q, errdp1_q;
  logic [1:0]         dp1_q;
  logic [VALUE_W-1:0] sum1_q;
  // stage 2: scaled product and range check
  logic               v2_q, neg2_q, err2_q;
  logic [1:0]         dp2_q;
  logic [PROD_W-1:0]  prod2_q;
  logic [R_W-1:0]     sumlo2_q;
  // stage 3: rounded value and its quotients
  logic               v3_q, neg3_q, err3_q;
  logic [1:0]         dp3_q;
  logic [R_W-1:0]     r3_q;
  logic [4:0]         q1000_q;
  logic [7:0]         q100_q;
  logic [10:0]        q10_q;
  // digit position counter
  logic [POS_W-1:0]   cnt_q, cnt_d;

  logic               en1, en2, en3;
  logic [VALUE_W-1:0] raw_u, rnd;
  logic [VALUE_W:0]   sum_wide;
  logic [R_W-1:0]     r_w;
  logic [28:0]        p1000;
  logic [27:0]        p100, p10;
  logic [3:0]         d [4];
  logic [1:0]         dpos;
  logic [2:0]         blank;
  logic [3:0]         minus;
  logic [SEG_W-1:0]   seg [4];

  // stall chain from the queue back to the input
  assign en3     = !v3_q || !full_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign push_o  = v3_q && !full_i;

  // magnitude plus rounding offset, negative values folded into one subtract
  assign raw_u = value_i;
  assign rnd   = round_add(dp_i[1:0]);
  always_comb begin
    if (value_i[VALUE_W-1]) begin
      sum_wide = {1'b1, {VALUE_W{1'b0}}} + {1'b0, rnd} - {1'b0, raw_u};
    end else begin
      sum_wide = {1'b0, raw_u} + {1'b0, rnd};
    end
  end

  // rounded value and quotients by 1000, 100 and 10
  assign r_w   = (dp2_q == DP_THREE) ? sumlo2_q
                                     : prod2_q[RECIP_SHIFT + R_W - 1:RECIP_SHIFT];
  assign p1000 = 29'(r_w) * 29'(DIV1000_M);
  assign p100  = 28'(r_w) * 28'(DIV100_M);
  assign p10   = 28'(r_w) * 28'(DIV10_M);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      cnt_q <= cnt_d;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (en1) begin
      neg1_q   <= value_i[VALUE_W-1];
      errdp1_q <= dp_i[2];
      dp1_q    <= dp_i[1:0];
      sum1_q   <= sum_wide[VALUE_W-1:0];
    end
    if (en2) begin
      neg2_q   <= neg1_q;
      dp2_q    <= dp1_q;
      err2_q   <= errdp1_q || (sum1_q >= ovf_limit(dp1_q, neg1_q));
      prod2_q  <= PROD_W'(sum1_q) * PROD_W'(recip(dp1_q));
      sumlo2_q <= sum1_q[R_W-1:0];
    end
    if (en3) begin
      neg3_q  <= neg2_q;
      dp3_q   <= dp2_q;
      err3_q  <= err2_q;
      r3_q    <= r_w;
      q1000_q <= p1000[DIV1000_S + 4:DIV1000_S];
      q100_q  <= p100[DIV100_S + 7:DIV100_S];
      q10_q   <= p10[DIV10_S + 10:DIV10_S];
    end
  end

  // decimal digits, blanking, sign and point
  always_comb begin
    d[0] = q1000_q[3:0];
    d[1] = 4'(q100_q - 8'(q1000_q) * 8'd10);
    d[2] = 4'(q10_q - 11'(q100_q) * 11'd10);
    d[3] = 4'(r3_q - 14'(q10_q) * 14'd10);
    dpos = DP_THREE - dp3_q;

    blank[0] = (dpos > 2'd0) && (d[0] == 4'd0);
    blank[1] = blank[0] && (dpos > 2'd1) && (d[1] == 4'd0);
    blank[2] = blank[1] && (dpos > 2'd2) && (d[2] == 4'd0);

    minus = '0;
    if (neg3_q) begin
      if (dpos == 2'd0) begin
        minus[0] = (d[0] == 4'd0);
      end else begin
        minus[0] = blank[0] && !blank[1];
        minus[1] = blank[1] && !blank[2];
        minus[2] = blank[2];
      end
    end

    for (int i = 0; i < 4; i++) begin
      if (minus[i]) begin
        seg[i] = SEG_MINUS;
      end else if ((i < 3) && blank[i % 3]) begin
        seg[i] = SEG_BLANK;
      end else begin
        seg[i] = glyph(d[i]);
      end
      if ((dp3_q != 2'd0) && (dpos == 2'(i))) begin
        seg[i] = seg[i] ^ SEG_POINT;
      end
    end
  end

  // queued entry and digit counter advance on normal words
  assign entry_o.err = err3_q;
  assign entry_o.seg = seg[cnt_q];
  assign entry_o.pos = cnt_q;
  assign cnt_d       = (push_o && !err3_q) ? cnt_q + 1'b1 : cnt_q;

endmodule

@@ hw/rtl/ssnf_back.sv @@
// Back end: turns queued entries into display frames, three frames for
// the error display, held in an output register. Uses ssnf_pkg.
module ssnf_back import ssnf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ssnf_entry_t      entry_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [SEG_W-1:0] segments_n_o,
  output logic [SEL_W-1:0] digit_select_o,
  output logic             is_error_o,
  output logic             last_frame_o
);

  logic             out_valid_q;
  logic [1:0]       beat_q, beat_d;
  logic [SEG_W-1:0] seg_n_q;
  logic [SEL_W-1:0] sel_q;
  logic             err_q, last_q;
  logic             load, done;
  logic [SEG_W-1:0] frame_seg;
  logic [POS_W-1:0] frame_pos;

  // frame contents for the head entry
  always_comb begin
    if (entry_i.err) begin
      frame_seg = (beat_q == BEAT_E) ? SEG_E : SEG_R;
      frame_pos = beat_q;
      done      = (beat_q == BEAT_LAST);
    end else begin
      frame_seg = entry_i.seg;
      frame_pos = entry_i.pos;
      done      = 1'b1;
    end
  end

  assign load   = !empty_i && (!out_valid_q || ready_i);
  assign pop_o  = load && done;
  assign beat_d = load ? (done ? BEAT_E : beat_q + 1'b1) : beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      beat_q      <= BEAT_E;
    end else begin
      beat_q <= beat_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      seg_n_q <= ~frame_seg;
      sel_q   <= SEL_FIRST >> frame_pos;
      err_q   <= entry_i.err;
      last_q  <= done;
    end
  end

  assign valid_o        = out_valid_q;
  assign segments_n_o   = seg_n_q;
  assign digit_select_o = sel_q;
  assign is_error_o     = err_q;
  assign last_frame_o   = last_q;

endmodule

@@ hw/rtl/seven_segment_number_formatter.sv @@
// Top level of the seven-segment number formatter: decimal places register,
// front end, entry queue and frame back end. Uses ssnf_pkg.
//
// Usage: each input word carries a signed value in thousandths. It is rounded
// to the decimal places register and yields one multiplexed digit frame
// (digit chosen by an internal counter that then advances), or three frames
// spelling Err when decimal places is above three or the value does not fit.
// Both channels are valid/ready; the user is to write the register with
// cfg_wdata_i via cfg_we_i only while the block is idle; it does not enforce this.
// A taken word passes three front stages, then the queue, then the output
// register, which presents the word's first frame.
// Throughput: one word per cycle for normal words unless stalled, set by the
// front pipeline; an error word occupies the back end for three frames.
// The queue between front and back absorbs error bursts and receiver stalls;
// when it and the front stages fill, in_ready_o drops. The output register
// holds a frame until out_ready_i takes it.
// Reset clears the register to zero decimal places, the digit counter to the
// first digit, and empties the pipeline and queue.
module seven_segment_number_formatter import ssnf_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [DP_W-1:0]           cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [VALUE_W-1:0] value_milli_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [SEG_W-1:0]          segments_n_o,
  output logic [SEL_W-1:0]          digit_select_o,
  output logic                      is_error_o,
  output logic                      last_frame_o
);

  logic [DP_W-1:0] decimal_places_q;
  logic            push, full, pop, empty;
  ssnf_entry_t     push_entry, head_entry;

  // decimal places register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decimal_places_q <= '0;
    end else if (cfg_we_i) begin
      decimal_places_q <= cfg_wdata_i;
    end
  end

  ssnf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .value_i (value_milli_i),
    .dp_i    (decimal_places_q),
    .push_o  (push),
    .entry_o (push_entry),
    .full_i  (full)
  );

  ssnf_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (empty)
  );

  ssnf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_i        (head_entry),
    .empty_i        (empty),
    .pop_o          (pop),
    .valid_o        (out_valid_o),
    .ready_i        (out_ready_i),
    .segments_n_o   (segments_n_o),
    .digit_select_o (digit_select_o),
    .is_error_o     (is_error_o),
    .last_frame_o   (last_frame_o)
  );

endmodule

@@ verif/ssnf_frame_checker.sv @@
// Frame checker for the seven-segment number formatter: watches the config
// port and both channels, predicts the digit frames and compares them.
// Depends on ssnf_pkg for widths and segment patterns.
module ssnf_frame_checker import ssnf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [DP_W-1:0]           cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic signed [VALUE_W-1:0] value_milli_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [SEG_W-1:0]          segments_n_i,
  input  logic [SEL_W-1:0]          digit_select_i,
  input  logic                      is_error_i,
  input  logic                      last_frame_i,
  output int                        frames_owed_o,
  output int                        mismatches_o
);

  // display limits of the rounded magnitude
  localparam int unsigned NEG_MAX = 999;
  localparam int unsigned POS_MAX = 9999;

  // glyphs of digits 9 down to 0, digit d at bits d*8 +: 8
  localparam logic [10*SEG_W-1:0] DIGIT_GLYPHS = {
    8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  typedef struct packed {
    logic [SEG_W-1:0] seg_n;
    logic [SEL_W-1:0] sel;
    logic             err;
    logic             last;
  } frame_t;

  frame_t          frames_due[$];
  logic [DP_W-1:0] places      = '0;
  logic [POS_W-1:0] digit_ctr  = '0;
  int              mismatch_count = 0;

  function automatic logic [SEG_W-1:0] digit_glyph(input int unsigned d);
    return DIGIT_GLYPHS[d*SEG_W +: SEG_W];
  endfunction

  // turn one accepted word into its expected frames
  function automatic void format_value(input logic signed [VALUE_W-1:0] v);
    logic             neg;
    logic             bad;
    logic             lead;
    int unsigned      mag;
    int unsigned      r;
    int unsigned      dpos;
    logic [SEG_W-1:0] seg [4];
    frame_t           f;
    neg = v[VALUE_W-1];
    mag = neg ? (32'h0100_0000 - {8'd0, v}) : {8'd0, v};
    bad = places > DP_THREE;
    r   = 0;
    if (!bad) begin
      case (places[1:0])
        2'd0:    r = (mag + 500) / 1000;
        2'd1:    r = (mag + 50) / 100;
        2'd2:    r = (mag + 5) / 10;
        default: r = mag;
      endcase
      bad = neg ? (r > NEG_MAX) : (r > POS_MAX);
    end
    if (bad) begin
      // Err spelled on the first three digits, counter untouched
      for (int k = 0; k < 3; k++) begin
        f.seg_n = ~((k == BEAT_E) ? SEG_E : SEG_R);
        f.sel   = SEL_FIRST >> k;
        f.err   = 1'b1;
        f.last  = (k == BEAT_LAST);
        frames_due.push_back(f);
      end
    end else begin
      dpos   = DP_THREE - places[1:0];
      seg[0] = digit_glyph((r / 1000) % 10);
      seg[1] = digit_glyph((r / 100) % 10);
      seg[2] = digit_glyph((r / 10) % 10);
      seg[3] = digit_glyph(r % 10);
      // blank leading zeros left of the point position
      lead = 1'b1;
      for (int i = 0; i < 3; i++) begin
        if (lead && i < dpos && seg[i] == digit_glyph(0)) seg[i] = SEG_BLANK;
        else lead = 1'b0;
      end
      // minus sign in front of the first shown digit
      if (neg) begin
        if (dpos == 0 && seg[0] == digit_glyph(0)) begin
          seg[0] = SEG_MINUS;
        end else begin
          for (int i = 1; i < 4; i++) begin
            if (seg[i-1] == SEG_BLANK && seg[i] != SEG_BLANK) seg[i-1] = SEG_MINUS;
          end
        end
      end
      if (places != 0) seg[dpos] = seg[dpos] ^ SEG_POINT;
      f.seg_n = ~seg[digit_ctr];
      f.sel   = SEL_FIRST >> digit_ctr;
      f.err   = 1'b0;
      f.last  = 1'b1;
      frames_due.push_back(f);
      digit_ctr = digit_ctr + 1'b1;
    end
  endfunction

  function automatic void check_field(input string name, input logic [SEG_W-1:0] want,
                                      input logic [SEG_W-1:0] got);
    if (got !== want) begin
      $error("%s expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // track config and words, then compare each taken frame with the oldest one due
  always @(posedge clk_i or negedge rst_ni) begin
    frame_t want;
    if (!rst_ni) begin
      places    = '0;
      digit_ctr = '0;
      frames_due.delete();
    end else begin
      if (cfg_we_i) places = cfg_wdata_i;
      if (in_valid_i && in_ready_i) format_value(value_milli_i);
      if (out_valid_i && out_ready_i) begin
        if (frames_due.size() == 0) begin
          $error("frame 0x%0h on digit 0x%0h with no word pending",
                 segments_n_i, digit_select_i);
          mismatch_count++;
        end else begin
          want = frames_due.pop_front();
          check_field("segments_n", want.seg_n, segments_n_i);
          check_field("digit_select", SEG_W'(want.sel), SEG_W'(digit_select_i));
          check_field("is_error", SEG_W'(want.err), SEG_W'(is_error_i));
          check_field("last_frame", SEG_W'(want.last), SEG_W'(last_frame_i));
        end
      end
    end
    frames_owed_o <= frames_due.size();
    mismatches_o  <= mismatch_count;
  end

endmodule

@@ verif/seven_segment_number_formatter_tb.sv @@
// Testbench top for the seven-segment number formatter: clock, reset,
// word and config stimulus, random receiver stalls and the verdict.
// Depends on ssnf_pkg, the block and ssnf_frame_checker.
module seven_segment_number_formatter_tb import ssnf_pkg::*;;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we;
  logic [DP_W-1:0]           cfg_wdata;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [VALUE_W-1:0] value_milli;
  logic                      out_valid;
  logic                      out_ready;
  logic [SEG_W-1:0]          segments_n;
  logic [SEL_W-1:0]          digit_select;
  logic                      is_error;
  logic                      last_frame;
  int                        frames_owed;
  int                        mismatches;

  logic [DP_W-1:0] places_set = '0;
  int  send_run  = 0;
  bit  send_calm = 1'b0;
  int  recv_run  = 0;
  bit  recv_calm = 1'b0;
  int  frames_taken = 0;

  // places settings of the random phases, extremes included
  localparam int NUM_PHASES = 12;
  localparam logic [NUM_PHASES*DP_W-1:0] PHASE_PLACES = {
    3'd1, 3'd2, 3'd0, 3'd3, 3'd6, 3'd5, 3'd4, 3'd7, 3'd3, 3'd2, 3'd1, 3'd0
  };

  seven_segment_number_formatter i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .value_milli_i  (value_milli),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .segments_n_o   (segments_n),
    .digit_select_o (digit_select),
    .is_error_o     (is_error),
    .last_frame_o   (last_frame)
  );

  ssnf_frame_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .value_milli_i  (value_milli),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .segments_n_i   (segments_n),
    .digit_select_i (digit_select),
    .is_error_i     (is_error),
    .last_frame_i   (last_frame),
    .frames_owed_o  (frames_owed),
    .mismatches_o   (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #1_600_000;
    $display("seven_segment_number_formatter_tb failed");
    $finish;
  end

  // idle cycles before the next word or frame, with stretches of none
  function automatic int draw_gap(inout int run_left, inout bit calm);
    if (run_left == 0) begin
      calm     = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(4, 24);
    end
    run_left--;
    return calm ? 0 : int'($urandom_range(0, 13));
  endfunction

  // random value in thousandths, aimed at the range shown for these places
  function automatic logic [VALUE_W-1:0] pick_value(input logic [DP_W-1:0] dp);
    int scale;
    int r;
    int m;
    int c;
    bit neg;
    scale = (dp == 0) ? 1000 : (dp == 1) ? 100 : (dp == 2) ? 10 : 1;
    c     = $urandom_range(0, 99);
    neg   = ($urandom_range(0, 9) < 4);
    if (c < 15) return VALUE_W'($urandom);
    if (c < 35) r = $urandom_range(0, 30);
    else if (c < 50) r = neg ? 999 : 9999;
    else r = $urandom_range(0, neg ? 999 : 9999);
    // near the overflow threshold, or anywhere around r
    if (c >= 35 && c < 50) m = r * scale + scale / 2 - 1 + int'($urandom_range(0, 2));
    else m = r * scale + int'($urandom_range(0, scale)) - scale / 2;
    if (neg) m = -m;
    return m[VALUE_W-1:0];
  endfunction

  // offer one word and hold it until taken
  task automatic send_word(input logic [VALUE_W-1:0] v);
    int gap;
    gap = draw_gap(send_run, send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    value_milli <= v;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // stop offering and wait until every frame due has been taken
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (frames_owed != 0);
  endtask

  task automatic set_places(input logic [DP_W-1:0] dp);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= dp;
    @(posedge clk_i);
    cfg_we     <= 1'b0;
    places_set = dp;
  endtask

  task automatic run_case(input logic [DP_W-1:0] dp, input int v);
    if (dp != places_set) set_places(dp);
    send_word(v[VALUE_W-1:0]);
  endtask

  // receiver: random stalls, plus two long hold-offs that back up the block
  initial begin
    int gap;
    forever begin
      gap = draw_gap(recv_run, recv_calm);
      if (frames_taken == 40 || frames_taken == 220) gap = 150;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      frames_taken++;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    value_milli <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: rounding edges, field extremes, overflow and sign cases
    set_places(3'd0);
    run_case(3'd0, 0);
    run_case(3'd0, 499);
    run_case(3'd0, 500);
    run_case(3'd0, -499);       // rounds to minus zero
    run_case(3'd0, -500);
    run_case(3'd0, 8388607);
    run_case(3'd0, -8388608);
    run_case(3'd0, -999499);
    run_case(3'd0, -999500);    // negative overflow
    run_case(3'd3, 9999);
    run_case(3'd3, 10000);      // positive overflow
    run_case(3'd3, -999);
    run_case(3'd3, -5);         // sign takes the leading zero
    run_case(3'd3, 0);
    run_case(3'd1, 49);
    run_case(3'd1, 50);
    run_case(3'd1, -1234);
    run_case(3'd2, 4);
    run_case(3'd2, -4);         // minus zero with point
    run_case(3'd2, 99994);
    run_case(3'd2, 99995);
    run_case(3'd7, 123);        // bad places
    run_case(3'd4, 0);

    // random phases, each at its places setting from PHASE_PLACES
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_places(PHASE_PLACES[p*DP_W +: DP_W]);
      repeat (24) send_word(pick_value(places_set));
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("seven_segment_number_formatter_tb passed");
    end else begin
      $display("seven_segment_number_formatter_tb failed");
    end
    $finish;
  end

endmodule
